// ===== rtl/core/pcsrm_pkg.sv =====
package pcsrm_pkg;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    localparam logic [2:0] PC_TCP   = 3'd0;
    localparam logic [2:0] PC_UDP   = 3'd1;
    localparam logic [2:0] PC_ICMP  = 3'd2;
    localparam logic [2:0] PC_OTHER = 3'd3;
    localparam logic [2:0] PC_NONE  = 3'd4;

    localparam logic [2:0] TC_HTTP  = 3'd0;
    localparam logic [2:0] TC_HTTPS = 3'd1;
    localparam logic [2:0] TC_DNS   = 3'd2;
    localparam logic [2:0] TC_SSH   = 3'd3;
    localparam logic [2:0] TC_VPN   = 3'd4;
    localparam logic [2:0] TC_XPORT = 3'd5;
    localparam logic [2:0] TC_OTHER = 3'd6;
    localparam logic [2:0] TC_NONE  = 3'd7;

    localparam logic [0:0] CMD_PACKET = 1'b0;
    localparam logic [0:0] CMD_READ   = 1'b1;

    localparam logic [0:0] CFG_WINDOW    = 1'b0;
    localparam logic [0:0] CFG_THRESHOLD = 1'b1;

    localparam logic [4:0] CIDX_LAST = 5'd16;

    // Map a port number to its category.
    function automatic logic [2:0] classify_port(input logic [15:0] p);
        logic [2:0] c;
        case (p)
            16'd80, 16'd8080:                       c = TC_HTTP;
            16'd443, 16'd8443:                      c = TC_HTTPS;
            16'd53:                                 c = TC_DNS;
            16'd22:                                 c = TC_SSH;
            16'd51820, 16'd1194:                    c = TC_VPN;
            16'd4719, 16'd8144, 16'd853, 16'd3478:  c = TC_XPORT;
            default:                                c = TC_OTHER;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic        command;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [3:0]  ip_header_words;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [63:0] timestamp_ns;
        logic [4:0]  counter_index;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  protocol_class;
        logic [2:0]  port_class;
        logic        high_rate_alert;
        logic [31:0] alert_source_ip;
        logic [31:0] alert_packet_count;
        logic [63:0] read_value;
    } t_out_item;

    // Classification handed from front stage to the counters.
    typedef struct packed {
        logic        is_read;
        logic        count_proto;
        logic        count_port;
        logic        track;
        logic [2:0]  pc;
        logic [2:0]  tc;
        logic [15:0] len;
        logic [4:0]  cidx;
    } t_class;

endpackage

// ===== rtl/core/pcsrm_in_if.sv =====
interface pcsrm_in_if
    import pcsrm_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pcsrm_out_if.sv =====
interface pcsrm_out_if
    import pcsrm_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/packet_class_stats_rate_monitor.sv =====
// Packet class statistics and per-source rate monitor.
// Input channel: packet summary items (command 0) or counter reads (command 1).
// Output channel: one result item per input item, in order.
// Result path: an accepted item is held in stage 1, then in the output queue.
// Throughput: one item per cycle while ready is high; the rate table memory
// is read in the cycle an item is accepted and written back via register r_wd,
// with forwarding of pending writes for back-to-back hits on the same entry.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data write rate window (0), alert
// threshold (1); the user must do so only while the block is idle (unchecked).
// Reset: counters clear at once; a clearing pass then walks the rate table,
// entry by entry, during which no item is accepted.
// Stall: a one-stage pipeline feeds a four-entry output queue; input ready
// drops when the queued items plus the one in flight reach four, and rises
// again the cycle after the receiver takes an item.
module packet_class_stats_rate_monitor
    import pcsrm_pkg::*;
#(
    parameter int RATE_TABLE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data,
    pcsrm_in_if.sink    in_ch,
    pcsrm_out_if.source out_ch
);
    logic [39:0] r_window;
    logic [31:0] r_thresh;
    t_class      cls;
    t_class      r_cls1;
    logic        acc;
    logic        r_v1;
    logic        busy;
    logic        alert;
    logic [31:0] asrc;
    logic [31:0] acnt;
    logic [63:0] rval;
    t_out_item   res;
    t_out_item   r_q [4];
    logic [2:0]  r_cnt;
    logic [1:0]  r_rp;
    logic [1:0]  r_wp;
    logic        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 40'd1000000000;
            r_thresh <= 32'd1000;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WINDOW) begin
                r_window <= i_cfg_data;
            end else begin
                r_thresh <= i_cfg_data[31:0];
            end
        end
    end

    pcsrm_classify u_cls (.i_item(in_ch.data), .o_cls(cls));

    // Room for everything in flight plus the new item.
    assign in_ch.ready = !busy
        && ({1'b0, r_cnt} + {3'd0, r_v1}) < 4'd4;
    assign acc = in_ch.valid && in_ch.ready;

    pcsrm_counters u_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(acc), .i_cls(cls),
        .o_read_value(rval)
    );

    pcsrm_rate #(.DEPTH(RATE_TABLE_DEPTH)) u_rate (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(acc), .i_track(cls.track),
        .i_src(in_ch.data.source_ip), .i_now(in_ch.data.timestamp_ns),
        .i_window(r_window), .i_threshold(r_thresh), .o_busy(busy),
        .o_alert(alert), .o_alert_src(asrc), .o_alert_cnt(acnt)
    );

    // Stage 1 carries classes alongside the rate lookup.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls1 <= cls;
    end

    always_comb begin
        res.result_kind        = r_cls1.is_read;
        res.protocol_class     = r_cls1.is_read ? PC_NONE : r_cls1.pc;
        res.port_class         = r_cls1.is_read ? TC_NONE : r_cls1.tc;
        res.high_rate_alert    = alert;
        res.alert_source_ip    = asrc;
        res.alert_packet_count = acnt;
        res.read_value         = rval;
    end

    // Output queue.
    assign pop          = out_ch.valid && out_ch.ready;
    assign out_ch.valid = r_cnt != 3'd0;
    assign out_ch.data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_q[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_rp  <= 2'd0;
            r_wp  <= 2'd0;
        end else begin
            if (r_v1) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, r_v1} - {2'b0, pop};
        end
    end
endmodule

// ===== rtl/core/pcsrm_classify.sv =====
module pcsrm_classify
    import pcsrm_pkg::*;
(
    input  t_in_item i_item,
    output t_class   o_cls
);
    logic [17:0] need;
    logic        v4;
    logic        v6;
    logic [2:0]  pc;
    logic [2:0]  tcd;
    logic [2:0]  tc;

    always_comb begin
        v4 = (i_item.frame_length >= 16'd34) && (i_item.ether_type == ETYPE_IPV4);
        v6 = (i_item.frame_length >= 16'd54) && (i_item.ether_type == ETYPE_IPV6);
        if (i_item.ip_protocol == 8'd6) begin
            pc = PC_TCP;
        end else if (i_item.ip_protocol == 8'd17) begin
            pc = PC_UDP;
        end else if ((v4 && i_item.ip_protocol == 8'd1) ||
                     (!v4 && i_item.ip_protocol == 8'd58)) begin
            pc = PC_ICMP;
        end else begin
            pc = PC_OTHER;
        end
        need = 18'd14 + {12'd0, i_item.ip_header_words, 2'b00}
             + ((pc == PC_TCP) ? 18'd20 : 18'd8);
        tcd = classify_port(i_item.dest_port);
        tc  = (tcd == TC_OTHER) ? classify_port(i_item.source_port) : tcd;

        o_cls.is_read     = (i_item.command == CMD_READ);
        o_cls.count_proto = !o_cls.is_read && (v4 || v6);
        o_cls.track       = !o_cls.is_read && v4;
        o_cls.count_port  = o_cls.track && (pc == PC_TCP || pc == PC_UDP)
                          && (need <= {2'b00, i_item.frame_length});
        o_cls.pc   = (v4 || v6) ? pc : PC_NONE;
        o_cls.tc   = o_cls.count_port ? tc : TC_NONE;
        o_cls.len  = i_item.frame_length;
        o_cls.cidx = i_item.counter_index;
    end
endmodule

// ===== rtl/core/pcsrm_counters.sv =====
module pcsrm_counters
    import pcsrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_class      i_cls,
    output logic [63:0] o_read_value
);
    localparam int NCNT = 17;

    logic [63:0] r_cnt [NCNT];
    logic [63:0] n_read;
    logic [4:0]  pidx;
    logic [4:0]  bidx;
    logic [4:0]  tidx;

    // Counter indexes follow the read map.
    always_comb begin
        pidx = 5'd2 + {2'd0, i_cls.pc};
        bidx = 5'd6 + {2'd0, i_cls.pc};
        tidx = 5'd10 + {2'd0, i_cls.tc};
        n_read = (i_cls.cidx <= CIDX_LAST) ? r_cnt[i_cls.cidx] : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCNT; k++) begin
                r_cnt[k] <= 64'd0;
            end
        end else if (i_en && !i_cls.is_read) begin
            r_cnt[0] <= r_cnt[0] + 64'd1;
            r_cnt[1] <= r_cnt[1] + {48'd0, i_cls.len};
            if (i_cls.count_proto) begin
                r_cnt[pidx] <= r_cnt[pidx] + 64'd1;
                r_cnt[bidx] <= r_cnt[bidx] + {48'd0, i_cls.len};
            end
            if (i_cls.count_port) begin
                r_cnt[tidx] <= r_cnt[tidx] + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_read_value <= i_cls.is_read ? n_read : 64'd0;
        end
    end
endmodule

// ===== rtl/core/pcsrm_rate.sv =====
module pcsrm_rate
    import pcsrm_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_track,
    input  logic [31:0] i_src,
    input  logic [63:0] i_now,
    input  logic [39:0] i_window,
    input  logic [31:0] i_threshold,
    output logic        o_busy,
    output logic        o_alert,
    output logic [31:0] o_alert_src,
    output logic [31:0] o_alert_cnt
);
    localparam int AW = $clog2(DEPTH);

    // Entry: valid, source, packets, window start.
    logic [128:0] r_mem [DEPTH];
    logic [128:0] r_rd;
    logic [AW:0]  r_clr;
    logic         r_s1;
    logic [31:0]  r_src1;
    logic [63:0]  r_now1;
    logic [AW-1:0] r_idx1;
    logic [128:0] r_wd;
    logic [AW-1:0] r_widx;
    logic         r_wv;
    logic [128:0] ent;
    logic [128:0] n_wd;
    logic         hit;
    logic         expd;
    logic [63:0]  age;
    logic [AW-1:0] idx0;

    assign idx0   = i_src[AW-1:0];
    assign o_busy = !r_clr[AW];

    // Stage 0: read, taking the write of this same edge when the entry matches;
    // stage 1: modify with bypass of last write.
    always_ff @(posedge i_clk) begin
        if (r_wv && r_widx == idx0) begin
            r_rd <= r_wd;
        end else begin
            r_rd <= r_mem[idx0];
        end
        if (r_wv) begin
            r_mem[r_widx] <= r_wd;
        end else if (o_busy) begin
            r_mem[r_clr[AW-1:0]] <= '0;
        end
    end

    always_comb begin
        ent  = (r_wv && r_widx == r_idx1) ? r_wd : r_rd;
        hit  = ent[128] && ent[127:96] == r_src1;
        age  = r_now1 - ent[63:0];
        expd = age > {24'd0, i_window};
        o_alert = r_s1 && hit && expd && ent[95:64] > i_threshold;
        o_alert_src = o_alert ? r_src1 : 32'd0;
        o_alert_cnt = o_alert ? ent[95:64] : 32'd0;
        if (hit && !expd) begin
            n_wd = {ent[128:96], ent[95:64] + {31'd0, ent[95:64] != 32'hFFFFFFFF},
                    ent[63:0]};
        end else begin
            n_wd = {1'b1, r_src1, 32'd1, r_now1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= 1'b0;
            r_wv  <= 1'b0;
            r_clr <= '0;
        end else begin
            if (o_busy && !r_wv) begin
                r_clr <= r_clr + 1'b1;
            end
            r_s1 <= i_en && i_track;
            r_wv <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src1 <= i_src;
        r_now1 <= i_now;
        r_idx1 <= idx0;
        r_wd   <= n_wd;
        r_widx <= r_idx1;
    end
endmodule
